### hw/rtl/owdps_pkg.sv
// ----------------------------------------------------------------------------
// owdps_pkg
// Shared widths, register map, reset values and helper functions for the
// one-wire dimming pulse sequencer.
// ----------------------------------------------------------------------------
package owdps_pkg;

	localparam int COUNT_BITS = 12;
	localparam int LEVEL_BITS = 5;
	localparam int DUR_BITS   = 12;
	localparam int ADDR_BITS  = 8;
	localparam int WIDE_BITS  = (COUNT_BITS > DUR_BITS) ? COUNT_BITS : DUR_BITS;
	localparam int PADDR_BITS = 5;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		REG_FORCE_REENTRY  = 3'd0,
		REG_DEVICE_ADDRESS = 3'd1,
		REG_SHORT_TIME     = 3'd2,
		REG_LONG_TIME      = 3'd3,
		REG_SHUTDOWN_TIME  = 3'd4,
		REG_DETECT_DELAY   = 3'd5,
		REG_DETECT_LOW     = 3'd6,
		REG_DETECT_WINDOW  = 3'd7
	} reg_index_t;

	localparam logic [ADDR_BITS-1:0] RST_DEVICE_ADDRESS = 8'h72;
	localparam logic [DUR_BITS-1:0]  RST_SHORT_TIME     = 12'd10;
	localparam logic [DUR_BITS-1:0]  RST_LONG_TIME      = 12'd50;
	localparam logic [DUR_BITS-1:0]  RST_SHUTDOWN_TIME  = 12'd3000;
	localparam logic [DUR_BITS-1:0]  RST_DETECT_DELAY   = 12'd200;
	localparam logic [DUR_BITS-1:0]  RST_DETECT_LOW     = 12'd500;
	localparam logic [DUR_BITS-1:0]  RST_DETECT_WINDOW  = 12'd1000;

	typedef struct packed {
		logic                 force_reentry;
		logic [ADDR_BITS-1:0] device_address;
		logic [DUR_BITS-1:0]  short_time;
		logic [DUR_BITS-1:0]  long_time;
		logic [DUR_BITS-1:0]  shutdown_time;
		logic [DUR_BITS-1:0]  detect_delay_time;
		logic [DUR_BITS-1:0]  detect_low_time;
		logic [DUR_BITS-1:0]  detect_window_time;
	} cfg_t;

	typedef struct packed {
		logic                  command;
		logic [LEVEL_BITS-1:0] level;
	} item_t;

	typedef struct packed {
		logic rejected;
		logic busy_res;
		logic line_out;
	} result_t;

	// A zero duration counts as one tick, a duration beyond the counter saturates.
	function automatic logic [COUNT_BITS-1:0] clamp_dur(input logic [DUR_BITS-1:0] d);
		logic [WIDE_BITS-1:0] dw;
		logic [WIDE_BITS-1:0] mw;
		dw = WIDE_BITS'(d);
		mw = WIDE_BITS'(CNT_MAX);
		if (d == '0) begin
			clamp_dur = COUNT_BITS'(1);
		end else if (dw > mw) begin
			clamp_dur = CNT_MAX;
		end else begin
			clamp_dur = COUNT_BITS'(dw);
		end
	endfunction

	// Bit of the byte being sent: the address byte or the zero-extended level.
	function automatic logic sel_bit(input logic slot, input logic [2:0] pos,
			input logic [LEVEL_BITS-1:0] lvl, input logic [ADDR_BITS-1:0] addr);
		logic [ADDR_BITS-1:0] byte_v;
		byte_v = slot ? ADDR_BITS'(lvl) : addr;
		sel_bit = byte_v[pos];
	endfunction

endpackage

### hw/rtl/owdps_regs.sv
// ----------------------------------------------------------------------------
// owdps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module owdps_regs
	import owdps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_index_t'(paddr[PADDR_BITS-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_reentry      <= 1'b0;
			cfg_q.device_address     <= RST_DEVICE_ADDRESS;
			cfg_q.short_time         <= RST_SHORT_TIME;
			cfg_q.long_time          <= RST_LONG_TIME;
			cfg_q.shutdown_time      <= RST_SHUTDOWN_TIME;
			cfg_q.detect_delay_time  <= RST_DETECT_DELAY;
			cfg_q.detect_low_time    <= RST_DETECT_LOW;
			cfg_q.detect_window_time <= RST_DETECT_WINDOW;
		end else if (wr_en) begin
			case (idx)
				REG_FORCE_REENTRY:  cfg_q.force_reentry      <= pwdata[0];
				REG_DEVICE_ADDRESS: cfg_q.device_address     <= pwdata[ADDR_BITS-1:0];
				REG_SHORT_TIME:     cfg_q.short_time         <= pwdata[DUR_BITS-1:0];
				REG_LONG_TIME:      cfg_q.long_time          <= pwdata[DUR_BITS-1:0];
				REG_SHUTDOWN_TIME:  cfg_q.shutdown_time      <= pwdata[DUR_BITS-1:0];
				REG_DETECT_DELAY:   cfg_q.detect_delay_time  <= pwdata[DUR_BITS-1:0];
				REG_DETECT_LOW:     cfg_q.detect_low_time    <= pwdata[DUR_BITS-1:0];
				REG_DETECT_WINDOW:  cfg_q.detect_window_time <= pwdata[DUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FORCE_REENTRY:  prdata = 32'(cfg_q.force_reentry);
			REG_DEVICE_ADDRESS: prdata = 32'(cfg_q.device_address);
			REG_SHORT_TIME:     prdata = 32'(cfg_q.short_time);
			REG_LONG_TIME:      prdata = 32'(cfg_q.long_time);
			REG_SHUTDOWN_TIME:  prdata = 32'(cfg_q.shutdown_time);
			REG_DETECT_DELAY:   prdata = 32'(cfg_q.detect_delay_time);
			REG_DETECT_LOW:     prdata = 32'(cfg_q.detect_low_time);
			REG_DETECT_WINDOW:  prdata = 32'(cfg_q.detect_window_time);
			default:            prdata = '0;
		endcase
	end

endmodule

### hw/rtl/owdps_seq.sv
// ----------------------------------------------------------------------------
// owdps_seq
// Pulse sequencer state machine: one tick or level request per enabled cycle,
// with the result for that item computed from the next state.
// ----------------------------------------------------------------------------
module owdps_seq
	import owdps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_SHUT  = 4'd1,
		PH_DDLY  = 4'd2,
		PH_DLOW  = 4'd3,
		PH_DWIN  = 4'd4,
		PH_START = 4'd5,
		PH_BLOW  = 4'd6,
		PH_BHIGH = 4'd7,
		PH_END   = 4'd8
	} phase_t;

	phase_t                phase_q, n_phase;
	logic                  pin_q, n_pin;
	logic                  chip_q, n_chip;
	logic [COUNT_BITS-1:0] tick_q, n_tick, tick_dec;
	logic [2:0]            pos_q, n_pos, pos_dec;
	logic                  slot_q, n_slot;
	logic [1:0]            passes_q, n_passes, passes_dec;
	logic [LEVEL_BITS-1:0] hold_q, n_hold;
	logic                  rej;
	logic                  bit_now;
	logic                  bit_next;

	assign tick_dec   = tick_q - COUNT_BITS'(1);
	assign pos_dec    = pos_q - 3'd1;
	assign passes_dec = passes_q - 2'd1;
	assign bit_now    = sel_bit(slot_q, pos_q, hold_q, cfg.device_address);
	assign bit_next   = sel_bit(slot_q, pos_dec, hold_q, cfg.device_address);

	always_comb begin
		n_phase  = phase_q;
		n_pin    = pin_q;
		n_chip   = chip_q;
		n_tick   = tick_q;
		n_pos    = pos_q;
		n_slot   = slot_q;
		n_passes = passes_q;
		n_hold   = hold_q;
		rej      = 1'b0;
		if (!item.command) begin
			if (phase_q != PH_IDLE) begin
				n_tick = tick_dec;
				if (tick_dec == '0) begin
					case (phase_q)
						PH_SHUT: begin
							n_phase = PH_DDLY;
							n_pin   = 1'b1;
							n_tick  = clamp_dur(cfg.detect_delay_time);
						end
						PH_DDLY: begin
							n_phase = PH_DLOW;
							n_pin   = 1'b0;
							n_tick  = clamp_dur(cfg.detect_low_time);
						end
						PH_DLOW: begin
							n_phase = PH_DWIN;
							n_pin   = 1'b1;
							n_tick  = clamp_dur(cfg.detect_window_time);
						end
						PH_DWIN: begin
							n_chip  = 1'b1;
							n_slot  = 1'b0;
							n_pos   = 3'd7;
							n_phase = PH_START;
							n_pin   = 1'b1;
							n_tick  = clamp_dur(cfg.short_time);
						end
						PH_START: begin
							n_phase = PH_BLOW;
							n_pin   = 1'b0;
							n_tick  = clamp_dur(bit_now ? cfg.short_time : cfg.long_time);
						end
						PH_BLOW: begin
							n_phase = PH_BHIGH;
							n_pin   = 1'b1;
							n_tick  = clamp_dur(bit_now ? cfg.long_time : cfg.short_time);
						end
						PH_BHIGH: begin
							if (pos_q == 3'd0) begin
								n_phase = PH_END;
								n_pin   = 1'b0;
								n_tick  = clamp_dur(cfg.short_time);
							end else begin
								n_pos   = pos_dec;
								n_phase = PH_BLOW;
								n_pin   = 1'b0;
								n_tick  = clamp_dur(bit_next ? cfg.short_time : cfg.long_time);
							end
						end
						PH_END: begin
							if (!slot_q) begin
								n_slot  = 1'b1;
								n_pos   = 3'd7;
								n_phase = PH_START;
								n_pin   = 1'b1;
								n_tick  = clamp_dur(cfg.short_time);
							end else begin
								n_passes = passes_dec;
								if (passes_dec != 2'd0) begin
									n_slot  = 1'b0;
									n_pos   = 3'd7;
									n_phase = PH_START;
									n_pin   = 1'b1;
									n_tick  = clamp_dur(cfg.short_time);
								end else begin
									n_phase = PH_IDLE;
									n_pin   = 1'b1;
									n_tick  = '0;
									n_slot  = 1'b0;
									n_pos   = 3'd7;
								end
							end
						end
						default: begin
							n_phase = PH_IDLE;
							n_tick  = '0;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else if (item.level == '0) begin
			n_pin  = 1'b0;
			n_chip = 1'b0;
		end else begin
			n_hold = item.level;
			n_slot = 1'b0;
			n_pos  = 3'd7;
			if (!chip_q || cfg.force_reentry) begin
				n_passes = 2'd2;
				n_phase  = PH_SHUT;
				n_pin    = 1'b0;
				n_tick   = clamp_dur(cfg.shutdown_time);
			end else begin
				n_passes = 2'd1;
				n_phase  = PH_START;
				n_pin    = 1'b1;
				n_tick   = clamp_dur(cfg.short_time);
			end
		end
	end

	assign result.line_out = n_pin;
	assign result.busy_res = (n_phase != PH_IDLE);
	assign result.rejected = rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pin_q    <= 1'b0;
			chip_q   <= 1'b0;
			tick_q   <= '0;
			pos_q    <= 3'd7;
			slot_q   <= 1'b0;
			passes_q <= 2'd0;
			hold_q   <= '0;
		end else if (step) begin
			phase_q  <= n_phase;
			pin_q    <= n_pin;
			chip_q   <= n_chip;
			tick_q   <= n_tick;
			pos_q    <= n_pos;
			slot_q   <= n_slot;
			passes_q <= n_passes;
			hold_q   <= n_hold;
		end
	end

endmodule

### hw/rtl/one_wire_dimming_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// one_wire_dimming_pulse_sequencer
// Drives an enable pin that doubles as a one-wire dimming bus.
// ----------------------------------------------------------------------------
// Usage: each transfer on the slave stream is one item. tuser carries the
// command (0 for a one-microsecond tick, 1 for a level request) and tdata
// carries the requested level. For every item exactly one result transfer
// leaves on the master stream with the pin level, the busy flag and the
// rejected flag after that item.
// The item is captured in an input register, then the sequencer updates its
// state and loads the output register with the result. Throughput is one
// item per cycle while the receiver does not stall, set by the single state
// update per cycle in the sequencer.
// When the receiver stalls, the output register holds its result and the
// input register absorbs one more item before tready falls.
// Reset clears both stages, puts the line low with the chip marked off, and
// loads the configuration registers with their default timings. The user must
// write them via the APB-style port while no item is in flight; not enforced.
// ----------------------------------------------------------------------------
module one_wire_dimming_pulse_sequencer
	import owdps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [4:0] level, [7:5] zero
	input  logic                  s_tuser,  // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [0] line_out, [1] busy_res, [2] rejected
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    step;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	owdps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign step     = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command <= s_tuser;
			item_s1.level   <= s_tdata[LEVEL_BITS-1:0];
		end
	end

	owdps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.rejected, res_s2.busy_res, res_s2.line_out};

`ifndef SYNTHESIS
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled while the pipeline had room");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_reject_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1])
		else $error("rejected request reported while idle");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the one-wire dimming pulse sequencer. A scoreboard
// class predicts the line level, busy flag and rejected flag after every
// accepted item and compares each result transfer against the oldest one.
// Requests and ticks are mixed with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import owdps_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_SHUTDOWN,
		SEQ_DET_DELAY,
		SEQ_DET_LOW,
		SEQ_DET_WINDOW,
		SEQ_BYTE_START,
		SEQ_BIT_LOW,
		SEQ_BIT_HIGH,
		SEQ_BYTE_END
	} seq_phase_t;

	class pulse_scoreboard;
		cfg_t                  cfg;
		logic                  pin;
		logic                  chip_on;
		seq_phase_t            ph;
		logic [COUNT_BITS-1:0] ticks;
		logic [2:0]            bitpos;
		logic                  slot;
		logic [1:0]            passes;
		logic [LEVEL_BITS-1:0] lvl_hold;
		result_t               line_states_due[$];
		int                    errors;
		int                    n_items;
		int                    n_checked;
		int                    n_rejects;
		int                    n_entries;
		int                    n_updates;

		function void reset_state();
			cfg.force_reentry      = 1'b0;
			cfg.device_address     = RST_DEVICE_ADDRESS;
			cfg.short_time         = RST_SHORT_TIME;
			cfg.long_time          = RST_LONG_TIME;
			cfg.shutdown_time      = RST_SHUTDOWN_TIME;
			cfg.detect_delay_time  = RST_DETECT_DELAY;
			cfg.detect_low_time    = RST_DETECT_LOW;
			cfg.detect_window_time = RST_DETECT_WINDOW;
			pin      = 1'b0;
			chip_on  = 1'b0;
			ph       = SEQ_IDLE;
			ticks    = '0;
			bitpos   = 3'd7;
			slot     = 1'b0;
			passes   = 2'd0;
			lvl_hold = '0;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] v);
			case (idx)
				REG_FORCE_REENTRY: cfg.force_reentry = v[0];
				REG_DEVICE_ADDRESS: cfg.device_address = v[7:0];
				REG_SHORT_TIME: cfg.short_time = v[11:0];
				REG_LONG_TIME: cfg.long_time = v[11:0];
				REG_SHUTDOWN_TIME: cfg.shutdown_time = v[11:0];
				REG_DETECT_DELAY: cfg.detect_delay_time = v[11:0];
				REG_DETECT_LOW: cfg.detect_low_time = v[11:0];
				REG_DETECT_WINDOW: cfg.detect_window_time = v[11:0];
				default: ;
			endcase
		endfunction

		function bit seq_busy();
			return ph != SEQ_IDLE;
		endfunction

		function int pending();
			return line_states_due.size();
		endfunction

		// A zero duration still lasts one tick.
		function void load(seq_phase_t p, logic line, logic [DUR_BITS-1:0] d);
			ph    = p;
			pin   = line;
			ticks = (d == '0) ? COUNT_BITS'(1) : COUNT_BITS'(d);
		endfunction

		// The address bits are taken from the live register value.
		function logic data_bit();
			logic [7:0] b;
			b = slot ? {3'b000, lvl_hold} : cfg.device_address;
			return b[bitpos];
		endfunction

		function void begin_bit();
			load(SEQ_BIT_LOW, 1'b0, data_bit() ? cfg.short_time : cfg.long_time);
		endfunction

		function void begin_byte(logic s);
			slot   = s;
			bitpos = 3'd7;
			load(SEQ_BYTE_START, 1'b1, cfg.short_time);
		endfunction

		function void next_phase();
			case (ph)
				SEQ_SHUTDOWN: load(SEQ_DET_DELAY, 1'b1, cfg.detect_delay_time);
				SEQ_DET_DELAY: load(SEQ_DET_LOW, 1'b0, cfg.detect_low_time);
				SEQ_DET_LOW: load(SEQ_DET_WINDOW, 1'b1, cfg.detect_window_time);
				SEQ_DET_WINDOW: begin
					chip_on = 1'b1;
					begin_byte(1'b0);
				end
				SEQ_BYTE_START: begin_bit();
				SEQ_BIT_LOW: load(SEQ_BIT_HIGH, 1'b1,
					data_bit() ? cfg.long_time : cfg.short_time);
				SEQ_BIT_HIGH: begin
					if (bitpos == 3'd0) begin
						load(SEQ_BYTE_END, 1'b0, cfg.short_time);
					end else begin
						bitpos = bitpos - 3'd1;
						begin_bit();
					end
				end
				SEQ_BYTE_END: begin
					if (!slot) begin
						begin_byte(1'b1);
					end else begin
						passes = passes - 2'd1;
						if (passes != 2'd0) begin
							begin_byte(1'b0);
						end else begin
							ph     = SEQ_IDLE;
							pin    = 1'b1;
							ticks  = '0;
							slot   = 1'b0;
							bitpos = 3'd7;
						end
					end
				end
				default: begin
					ph    = SEQ_IDLE;
					ticks = '0;
				end
			endcase
		endfunction

		function void accept_item(logic cmd, logic [LEVEL_BITS-1:0] lvl);
			result_t r;
			r.rejected = 1'b0;
			n_items++;
			if (!cmd) begin
				if (ph != SEQ_IDLE) begin
					ticks = ticks - COUNT_BITS'(1);
					if (ticks == '0)
						next_phase();
				end
			end else if (ph != SEQ_IDLE) begin
				r.rejected = 1'b1;
				n_rejects++;
			end else if (lvl == '0) begin
				pin     = 1'b0;
				chip_on = 1'b0;
			end else begin
				lvl_hold = lvl;
				if (!chip_on || cfg.force_reentry) begin
					passes = 2'd2;
					slot   = 1'b0;
					bitpos = 3'd7;
					load(SEQ_SHUTDOWN, 1'b0, cfg.shutdown_time);
					n_entries++;
				end else begin
					passes = 2'd1;
					begin_byte(1'b0);
					n_updates++;
				end
			end
			r.line_out = pin;
			r.busy_res = (ph != SEQ_IDLE);
			line_states_due.push_back(r);
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		endtask

		task check_line_state(logic [7:0] d);
			result_t e;
			n_checked++;
			if (line_states_due.size() == 0) begin
				report("unexpected result transfer", d, 0);
			end else begin
				e = line_states_due.pop_front();
				if (d[0] !== e.line_out)
					report("line_out", d[0], e.line_out);
				if (d[1] !== e.busy_res)
					report("busy_res", d[1], e.busy_res);
				if (d[2] !== e.rejected)
					report("rejected", d[2], e.rejected);
			end
		endtask

		task check_drained();
			if (line_states_due.size() != 0)
				report("results never delivered", line_states_due.size(), 0);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;  // [4:0] level, [7:5] zero
	logic                  s_tuser;  // [0] command
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;  // [0] line_out, [1] busy_res, [2] rejected
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	pulse_scoreboard sb;
	bit quiet;
	int rx_hold;
	int idle_cycles;

	one_wire_dimming_pulse_sequencer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random stall bursts, plus a long hold on request.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_line_state(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [LEVEL_BITS-1:0] lvl);
		int gap;
		if (!quiet && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, lvl};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.accept_item(cmd, lvl);
	endtask

	task automatic tick();
		send_item(1'b0, LEVEL_BITS'($urandom_range(0, 31)));
	endtask

	task automatic run_until_idle();
		while (sb.seq_busy()) tick();
	endtask

	// Stop offering items and wait for every outstanding result.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_FORCE_REENTRY, 32'(c.force_reentry));
		write_reg(REG_DEVICE_ADDRESS, 32'(c.device_address));
		write_reg(REG_SHORT_TIME, 32'(c.short_time));
		write_reg(REG_LONG_TIME, 32'(c.long_time));
		write_reg(REG_SHUTDOWN_TIME, 32'(c.shutdown_time));
		write_reg(REG_DETECT_DELAY, 32'(c.detect_delay_time));
		write_reg(REG_DETECT_LOW, 32'(c.detect_low_time));
		write_reg(REG_DETECT_WINDOW, 32'(c.detect_window_time));
	endtask

	function automatic cfg_t rand_cfg(bit slow_entry);
		cfg_t c;
		int   emax;
		emax = slow_entry ? 100 : 5;
		c.force_reentry      = 1'($urandom_range(0, 1));
		c.device_address     = 8'($urandom_range(0, 255));
		c.short_time         = DUR_BITS'($urandom_range(0, 3));
		c.long_time          = DUR_BITS'($urandom_range(0, slow_entry ? 8 : 4));
		c.shutdown_time      = DUR_BITS'($urandom_range(0, emax));
		c.detect_delay_time  = DUR_BITS'($urandom_range(0, emax));
		c.detect_low_time    = DUR_BITS'($urandom_range(0, emax));
		c.detect_window_time = DUR_BITS'($urandom_range(0, emax));
		return c;
	endfunction

	initial begin
		cfg_t c;
		logic [LEVEL_BITS-1:0] lvl;
		int n_req;

		sb = new();
		sb.reset_state();
		quiet       = 1'b0;
		rx_hold     = 0;
		idle_cycles = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Short timings, with zero-length registers that must act as one tick.
		c.force_reentry      = 1'b0;
		c.device_address     = 8'hA5;
		c.short_time         = 12'd0;
		c.long_time          = 12'd2;
		c.shutdown_time      = 12'd0;
		c.detect_delay_time  = 12'd1;
		c.detect_low_time    = 12'd0;
		c.detect_window_time = 12'd2;
		program_regs(c);

		// Idle tick, idle shutdown, entry with requests refused while busy.
		tick();
		send_item(1'b1, 5'd0);
		tick();
		send_item(1'b1, 5'd31);
		send_item(1'b1, 5'd1);
		send_item(1'b1, 5'd0);
		tick();
		run_until_idle();
		// Chip is on now, so this level goes out once without an entry.
		send_item(1'b1, 5'd1);
		send_item(1'b1, 5'd31);
		run_until_idle();
		send_item(1'b1, 5'd0);
		tick();
		settle();
		write_reg(REG_FORCE_REENTRY, 32'd1);
		write_reg(REG_DEVICE_ADDRESS, 32'hFF);
		send_item(1'b1, 5'd1);
		run_until_idle();
		send_item(1'b1, 5'd16);
		run_until_idle();
		settle();

		// Long timings; they are cut back while the shutdown is running.
		c.force_reentry      = 1'b1;
		c.device_address     = 8'h00;
		c.short_time         = 12'd4095;
		c.long_time          = 12'd4095;
		c.shutdown_time      = 12'd60;
		c.detect_delay_time  = 12'd4095;
		c.detect_low_time    = 12'd4095;
		c.detect_window_time = 12'd4095;
		program_regs(c);
		send_item(1'b1, 5'd31);
		repeat (20) tick();
		settle();
		c.force_reentry      = 1'b0;
		c.device_address     = 8'hFF;
		c.short_time         = 12'd1;
		c.long_time          = 12'd1;
		c.shutdown_time      = 12'd1;
		c.detect_delay_time  = 12'd1;
		c.detect_low_time    = 12'd1;
		c.detect_window_time = 12'd1;
		program_regs(c);
		run_until_idle();
		settle();

		// Random phases: mostly ticks, requests more likely while idle.
		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				quiet = 1'b1;
			program_regs(rand_cfg(p == 3));
			for (int i = 0; i < 100; i++) begin
				if (p == 2 && i == 40)
					rx_hold = 80;
				if (p == 4 && i == 80)
					settle();
				n_req = sb.seq_busy() ? 15 : 3;
				if ($urandom_range(1, n_req) == 1) begin
					lvl = ($urandom_range(0, 4) == 0) ? 5'd0
						: LEVEL_BITS'($urandom_range(1, 31));
					send_item(1'b1, lvl);
				end else begin
					tick();
				end
			end
			settle();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		sb.check_drained();

		$display("Run covered %0d items and %0d results: %0d entry sequences, %0d updates",
			sb.n_items, sb.n_checked, sb.n_entries, sb.n_updates);
		$display("without entry, %0d requests refused while busy, %0d mismatches.",
			sb.n_rejects, sb.errors);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
